// File: hw/rtl/aocl_pkg.sv
// ----------------------------------------------------------------------------
// aocl_pkg
// Shared types and constants for the accelerometer offset calibration and
// low-pass filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package aocl_pkg;

  // Field geometry
  localparam int unsigned NumFields  = 3;
  localparam int unsigned AxesDefault = 3;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned SumW       = 32;
  localparam int unsigned AlphaW     = 8;
  localparam int unsigned AlphaShift = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  // Register reset values
  localparam logic [SampleW-1:0] CalibSamplesRst = 16'd64;
  localparam logic [AlphaW-1:0]  FilterAlphaRst  = 8'd122;

  // Restoring divider: one quotient bit per cycle over the sum width
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CALIB_SAMPLES = 1'b0,
    CFG_FILTER_ALPHA  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_COMMIT,
    OP_DIFF,
    OP_FILT
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_COMMIT,
    ST_DIFF,
    ST_FILT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   capture;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic calib_full;
    logic out_free;
  } dp_sts_t;

endpackage : aocl_pkg

`default_nettype wire

// File: hw/rtl/accel_offset_calibrate_lpf_core.sv
// ----------------------------------------------------------------------------
// accel_offset_calibrate_lpf_core
// Accelerometer offset calibration by averaging, followed by a first-order
// low-pass filter on offset-corrected samples.
// ----------------------------------------------------------------------------
// One request is processed at a time. A measure request runs one subtract
// step and one multiply step per axis, on a single shared multiplier. A
// calibration request that does not complete the count returns no result;
// the one that completes it runs the restoring divider, which produces one
// quotient bit per cycle over the 32-bit sums (all axes in parallel).
// A result waiting in the output register holds the controller in its emit
// state: the next result is loaded at the edge the pending one is taken, and
// no new request is accepted until then.
`default_nettype none

module accel_offset_calibrate_lpf_core #(
  parameter int unsigned AXES = aocl_pkg::AxesDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [aocl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [aocl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           in_action_i,
  input  wire logic [aocl_pkg::SampleW-1:0]   in_sample_x_i,
  input  wire logic [aocl_pkg::SampleW-1:0]   in_sample_y_i,
  input  wire logic [aocl_pkg::SampleW-1:0]   in_sample_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                out_kind_o,
  output logic [aocl_pkg::SampleW-1:0]        out_value_x_o,
  output logic [aocl_pkg::SampleW-1:0]        out_value_y_o,
  output logic [aocl_pkg::SampleW-1:0]        out_value_z_o
);
  import aocl_pkg::*;

  localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] axis;

  aocl_ctrl #(
    .AXES (AXES),
    .AW   (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .axis_o      (axis)
  );

  aocl_dp #(
    .AXES (AXES),
    .AW   (AW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .axis_i        (axis),
    .sts_o         (sts),
    .in_action_i   (in_action_i),
    .in_sample_x_i (in_sample_x_i),
    .in_sample_y_i (in_sample_y_i),
    .in_sample_z_i (in_sample_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .out_value_x_o (out_value_x_o),
    .out_value_y_o (out_value_y_o),
    .out_value_z_o (out_value_z_o)
  );

  // No new request while the datapath is working on one
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op != OP_NONE) |-> !in_ready_o)
    else $error("request accepted while datapath busy");

  // A result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Offsets are committed only right after the last divide step
  a_commit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_DIV_COMMIT) |-> ($past(cmd.op) == OP_DIV_STEP))
    else $error("offset commit without completed division");

endmodule : accel_offset_calibrate_lpf_core

`default_nettype wire

// File: hw/rtl/aocl_dp.sv
// ----------------------------------------------------------------------------
// aocl_dp
// Datapath: configuration registers, calibration sums, per-axis restoring
// dividers, offsets, filter state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aocl_dp #(
  parameter int unsigned AXES = aocl_pkg::AxesDefault,
  parameter int unsigned AW   = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [aocl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [aocl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire aocl_pkg::dp_cmd_t              cmd_i,
  input  wire logic [AW-1:0]                  axis_i,
  output aocl_pkg::dp_sts_t                   sts_o,
  input  wire logic                           in_action_i,
  input  wire logic [aocl_pkg::SampleW-1:0]   in_sample_x_i,
  input  wire logic [aocl_pkg::SampleW-1:0]   in_sample_y_i,
  input  wire logic [aocl_pkg::SampleW-1:0]   in_sample_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                out_kind_o,
  output logic [aocl_pkg::SampleW-1:0]        out_value_x_o,
  output logic [aocl_pkg::SampleW-1:0]        out_value_y_o,
  output logic [aocl_pkg::SampleW-1:0]        out_value_z_o
);
  import aocl_pkg::*;

  localparam int unsigned ProdW = SampleW + 1 + AlphaW + 1;

  logic [SampleW-1:0]  samples_q;
  logic [AlphaW-1:0]   alpha_q;
  logic [SampleW-1:0]  count_q;
  logic [SampleW-1:0]  cnt_inc;

  logic [SampleW-1:0]  fs_q  [AXES];
  logic [SampleW-1:0]  off_q [AXES];
  logic [SumW-1:0]     sum_q [AXES];

  logic                action_q;
  logic [SampleW-1:0]  smp_q [NumFields];
  logic [SampleW-1:0]  x_ax  [AXES];

  logic [SumW-1:0]     quo_q [AXES];
  logic [SampleW-1:0]  rem_q [AXES];
  logic                neg_q [AXES];
  logic [SampleW:0]    trial [AXES];
  logic                ge    [AXES];

  logic [SampleW-1:0]  centered;
  logic [SampleW:0]    diff_d;
  logic signed [SampleW:0]  diff_q;
  logic signed [AlphaW:0]   alpha_s;
  logic signed [ProdW-1:0]  prod;
  logic [SampleW-1:0]  fs_new;

  logic                out_valid_q;
  logic                out_kind_q;
  logic [SampleW-1:0]  out_val_q [NumFields];
  logic [SampleW-1:0]  res_fld   [NumFields];

  // Axis inputs beyond the third field read as zero
  for (genvar a = 0; a < AXES; a++) begin : g_axis_in
    if (a < NumFields) begin : g_used
      assign x_ax[a] = smp_q[a];
    end else begin : g_zero
      assign x_ax[a] = '0;
    end
  end

  // Result fields beyond the configured axes read as zero
  for (genvar f = 0; f < NumFields; f++) begin : g_field
    if (f < AXES) begin : g_used
      assign res_fld[f] = action_q ? off_q[f] : fs_q[f];
    end else begin : g_zero
      assign res_fld[f] = '0;
    end
  end

  assign cnt_inc = count_q + 16'd1;
  // A wrapped count never completes; zero samples behaves like one
  assign sts_o.calib_full = (cnt_inc != '0) && (cnt_inc >= samples_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      trial[a] = {rem_q[a], quo_q[a][SumW-1]};
      ge[a]    = trial[a] >= {1'b0, count_q};
    end
  end

  always_comb begin
    centered = x_ax[axis_i] - off_q[axis_i];
    diff_d   = {centered[SampleW-1], centered} - {fs_q[axis_i][SampleW-1], fs_q[axis_i]};
    alpha_s  = $signed({1'b0, alpha_q});
    prod     = diff_q * alpha_s;
    // Arithmetic shift, then wrap the update to the state width
    fs_new   = fs_q[axis_i] + prod[SampleW+AlphaShift-1:AlphaShift];
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= CalibSamplesRst;
      alpha_q   <= FilterAlphaRst;
      count_q   <= '0;
      for (int a = 0; a < AXES; a++) begin
        fs_q[a]  <= '0;
        off_q[a] <= '0;
        sum_q[a] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CALIB_SAMPLES: samples_q <= cfg_wdata_i;
          CFG_FILTER_ALPHA:  alpha_q   <= cfg_wdata_i[AlphaW-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_ACC: begin
          count_q <= cnt_inc;
          for (int a = 0; a < AXES; a++) begin
            sum_q[a] <= sum_q[a] + {{(SumW-SampleW){x_ax[a][SampleW-1]}}, x_ax[a]};
          end
        end
        OP_DIV_COMMIT: begin
          count_q <= '0;
          for (int a = 0; a < AXES; a++) begin
            sum_q[a] <= '0;
            off_q[a] <= neg_q[a] ? (16'd0 - quo_q[a][SampleW-1:0]) : quo_q[a][SampleW-1:0];
          end
        end
        OP_FILT: fs_q[axis_i] <= fs_new;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_action_i;
      smp_q[0] <= in_sample_x_i;
      smp_q[1] <= in_sample_y_i;
      smp_q[2] <= in_sample_z_i;
    end
    case (cmd_i.op)
      OP_DIV_LOAD: begin
        for (int a = 0; a < AXES; a++) begin
          neg_q[a] <= sum_q[a][SumW-1];
          quo_q[a] <= sum_q[a][SumW-1] ? (32'd0 - sum_q[a]) : sum_q[a];
          rem_q[a] <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int a = 0; a < AXES; a++) begin
          rem_q[a] <= ge[a] ? SampleW'(trial[a] - {1'b0, count_q}) : trial[a][SampleW-1:0];
          quo_q[a] <= {quo_q[a][SumW-2:0], ge[a]};
        end
      end
      OP_DIFF: diff_q <= $signed(diff_d);
      default: ;
    endcase
    if (cmd_i.emit) begin
      out_kind_q <= action_q;
      for (int f = 0; f < NumFields; f++) begin
        out_val_q[f] <= res_fld[f];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_value_x_o = out_val_q[0];
  assign out_value_y_o = out_val_q[1];
  assign out_value_z_o = out_val_q[2];

endmodule : aocl_dp

`default_nettype wire

// File: hw/rtl/aocl_ctrl.sv
// ----------------------------------------------------------------------------
// aocl_ctrl
// Controller: sequences accumulation, division, per-axis filtering and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aocl_ctrl #(
  parameter int unsigned AXES = aocl_pkg::AxesDefault,
  parameter int unsigned AW   = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_action_i,
  output logic                    in_ready_o,
  input  wire aocl_pkg::dp_sts_t  sts_i,
  output aocl_pkg::dp_cmd_t       cmd_o,
  output logic [AW-1:0]           axis_o
);
  import aocl_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [AW-1:0]    axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    axis_d        = axis_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.capture = 1'b0;
    cmd_o.emit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          axis_d        = '0;
          state_d       = in_action_i ? ST_ACC : ST_DIFF;
        end
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        // Drop back to idle unless this sample completes the count
        state_d  = sts_i.calib_full ? ST_DIV_LOAD : ST_IDLE;
      end
      ST_DIV_LOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        step_d   = '0;
        state_d  = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = ST_DIV_COMMIT;
        end
      end
      ST_DIV_COMMIT: begin
        cmd_o.op = OP_DIV_COMMIT;
        state_d  = ST_EMIT;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_FILT;
      end
      ST_FILT: begin
        cmd_o.op = OP_FILT;
        if (axis_q == AW'(AXES - 1)) begin
          state_d = ST_EMIT;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_DIFF;
        end
      end
      ST_EMIT: begin
        // Hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign axis_o = axis_q;

endmodule : aocl_ctrl

`default_nettype wire
